/* rtl/ptt_pkg.sv */
// ptt_pkg: sizes, codes and word types of the periodic / one-shot timer table
// used by the channel interfaces, ptt_reload and the table core
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int SLOTS    = 16;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int ID_W     = 32;
    localparam int TAG_W    = 8;
    localparam int MS_W     = 32;
    localparam int RELOAD_W = 29;
    localparam int KIND_W   = 3;
    localparam int REQ_W    = 2;

    // ms / 10 as a multiply by a reciprocal, exact over the full 32-bit range
    localparam int             PROD_W    = 2 * MS_W;
    localparam int             DIV_SHIFT = 35;
    localparam logic [MS_W-1:0] RECIP_10 = 32'hCCCC_CCCD;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [MS_W-1:0]  period_ms;
        logic             one_shot;
        logic [ID_W-1:0]  timer_id;
        logic [TAG_W-1:0] handler_tag;
    } t_req;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [ID_W-1:0]   out_id;
        logic [TAG_W-1:0]  out_tag;
        logic              last;
    } t_res;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [TAG_W-1:0]    tag;
        logic                once;
        logic [RELOAD_W-1:0] reload;
        logic [RELOAD_W-1:0] count;
    } t_entry;

endpackage

/* rtl/ptt_if.sv */
// ptt_req_if / ptt_res_if: valid-ready channels for request and result words
// depends on ptt_pkg for the word types
`timescale 1ns / 1ps

interface ptt_req_if import ptt_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ptt_res_if import ptt_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/ptt_ram.sv */
// ptt_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ptt_reload.sv */
// ptt_reload: reload ticks max(1, ms / 10) via a registered reciprocal multiply
// depends on ptt_pkg; result is valid in the cycle after the period is presented
`timescale 1ns / 1ps

module ptt_reload import ptt_pkg::*; (
    input  logic                i_clk,
    input  logic [MS_W-1:0]     i_ms,
    output logic [RELOAD_W-1:0] o_ticks
);

    logic [PROD_W-1:0]   r_prod;
    logic [RELOAD_W-1:0] w_quot;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_ms) * PROD_W'(RECIP_10);
    end

    assign w_quot  = r_prod[DIV_SHIFT + RELOAD_W - 1:DIV_SHIFT];
    assign o_ticks = (w_quot == '0) ? RELOAD_W'(1) : w_quot;

endmodule

/* rtl/periodic_oneshot_timer_table_core.sv */
// Timer table of SLOTS entries held in one ram of entry words, oldest first.
// An add goes from acceptance through the multiply, the write and the result, in that order.
// A remove or tick walks the live entries once at one entry per cycle, compacting
// the table in the same pass; a tick holds an entry while its fired word cannot be
// placed, and the final word likewise waits on the result channel.
// The single ram read port sets that rate. No clearing pass after reset.
// depends on ptt_pkg, ptt_if, ptt_ram and ptt_reload
`timescale 1ns / 1ps

module periodic_oneshot_timer_table_core import ptt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptt_req_if.sink   i_req,
    ptt_res_if.source o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_live, n_live;
    logic [ID_W-1:0]   r_next_id, n_next_id;
    logic [CNT_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_wr, n_wr;
    logic              r_found, n_found;
    logic [REQ_W-1:0]  r_req_type, n_req_type;
    logic              r_once, n_once;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [ID_W-1:0]   r_tid, n_tid;
    logic [KIND_W-1:0] r_fin, n_fin;
    logic [ID_W-1:0]   r_fin_id, n_fin_id;
    logic              r_out_valid;
    t_res              r_out;

    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [IDX_W-1:0]     w_raddr;
    t_entry               w_wdata;
    logic [$bits(t_entry)-1:0] w_rdata;
    t_entry               w_rd_entry;
    t_entry               w_upd;
    logic [RELOAD_W-1:0]  w_ticks;
    logic [RELOAD_W-1:0]  w_cnt_dec;
    logic [CNT_W-1:0]     w_rd_inc;
    logic                 w_fire;
    logic                 w_keep;
    logic                 w_out_free;
    logic                 w_emit;
    t_res                 w_emit_res;

    ptt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ptt_reload u_reload (
        .i_clk   (i_clk),
        .i_ms    (i_req.data.period_ms),
        .o_ticks (w_ticks)
    );

    assign w_rd_entry  = t_entry'(w_rdata);
    assign w_cnt_dec   = w_rd_entry.count - RELOAD_W'(1);
    assign w_rd_inc    = r_rd + CNT_W'(1);
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_fire      = (r_req_type == REQ_TICK) && (w_cnt_dec == '0);
    assign i_req.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        n_state    = r_state;
        n_live     = r_live;
        n_next_id  = r_next_id;
        n_rd       = r_rd;
        n_wr       = r_wr;
        n_found    = r_found;
        n_req_type = r_req_type;
        n_once     = r_once;
        n_tag      = r_tag;
        n_tid      = r_tid;
        n_fin      = r_fin;
        n_fin_id   = r_fin_id;
        w_we       = 1'b0;
        w_waddr    = r_wr[IDX_W-1:0];
        w_raddr    = r_rd[IDX_W-1:0];
        w_upd      = w_rd_entry;
        w_wdata    = w_rd_entry;
        w_keep     = 1'b1;
        w_emit     = 1'b0;
        w_emit_res = '0;

        unique case (r_state)
            ST_IDLE: begin
                n_rd    = '0;
                n_wr    = '0;
                n_found = 1'b0;
                w_raddr = '0;
                if (i_req.valid) begin
                    n_req_type = i_req.data.req_type;
                    n_once     = i_req.data.one_shot;
                    n_tag      = i_req.data.handler_tag;
                    n_tid      = i_req.data.timer_id;
                    n_fin_id   = '0;
                    case (i_req.data.req_type)
                        REQ_ADD: begin
                            if (r_live == CNT_W'(SLOTS)) begin
                                n_fin   = KIND_FULL;
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_ADD;
                            end
                        end
                        REQ_REMOVE: begin
                            n_fin   = KIND_NOT_FOUND;
                            n_state = (r_live == '0) ? ST_DONE : ST_WALK;
                        end
                        REQ_TICK: begin
                            n_fin   = KIND_TICK_DONE;
                            n_state = (r_live == '0) ? ST_DONE : ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD: begin
                w_we           = 1'b1;
                w_waddr        = r_live[IDX_W-1:0];
                w_wdata.id     = r_next_id;
                w_wdata.tag    = r_tag;
                w_wdata.once   = r_once;
                w_wdata.reload = w_ticks;
                w_wdata.count  = w_ticks;
                n_live         = r_live + CNT_W'(1);
                n_next_id      = r_next_id + ID_W'(1);
                n_fin          = KIND_ADDED;
                n_fin_id       = r_next_id;
                n_state        = ST_DONE;
            end
            ST_WALK: begin
                // hold the entry while a fired word cannot be placed
                if (!(w_fire && !w_out_free)) begin
                    if (r_req_type == REQ_REMOVE) begin
                        if (!r_found && (w_rd_entry.id == r_tid)) begin
                            w_keep  = 1'b0;
                            n_found = 1'b1;
                        end
                    end else begin
                        w_upd.count = w_fire ? w_rd_entry.reload : w_cnt_dec;
                        if (w_fire) begin
                            w_emit                 = 1'b1;
                            w_emit_res.result_kind = KIND_FIRED;
                            w_emit_res.out_id      = w_rd_entry.id;
                            w_emit_res.out_tag     = w_rd_entry.tag;
                            w_keep                 = !w_rd_entry.once;
                        end
                    end
                    // write slot trails the read slot, so no overlap with the read
                    if (w_keep) begin
                        w_we    = 1'b1;
                        w_wdata = w_upd;
                        n_wr    = r_wr + CNT_W'(1);
                    end
                    n_rd    = w_rd_inc;
                    w_raddr = w_rd_inc[IDX_W-1:0];
                    if (w_rd_inc == r_live) begin
                        n_live  = n_wr;
                        n_state = ST_DONE;
                        if (r_req_type == REQ_REMOVE) begin
                            n_fin = n_found ? KIND_REMOVED : KIND_NOT_FOUND;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_emit                 = 1'b1;
                    w_emit_res.result_kind = r_fin;
                    w_emit_res.out_id      = r_fin_id;
                    w_emit_res.last        = 1'b1;
                    n_state                = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_live      <= '0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_live    <= n_live;
            r_next_id <= n_next_id;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd       <= n_rd;
        r_wr       <= n_wr;
        r_found    <= n_found;
        r_req_type <= n_req_type;
        r_once     <= n_once;
        r_tag      <= n_tag;
        r_tid      <= n_tid;
        r_fin      <= n_fin;
        r_fin_id   <= n_fin_id;
        if (w_emit) begin
            r_out <= w_emit_res;
        end
    end

endmodule
